// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked, reset-gated assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a |-> b on clk, off during reset
`define ASSERT_IMP(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed");

// a |=> b on clk, off during reset
`define ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// File: sv/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU profiler package
// Shared widths, register indexes and queue word type.
// ----------------------------------------------------------------------------
package lru_pkg;
	localparam int STACK_DEPTH = 256;
	localparam int ADDR_BITS   = 24;
	localparam int NUM_SIZES   = 4;
	localparam int POS_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = 2;
	localparam int CNT_W       = 32;
	localparam int SIZE_W      = 9;
	localparam int NS_W        = 3;
	localparam int REG_W       = 3;

	localparam logic [REG_W-1:0] REG_SIZES_IN_USE = 3'd0;
	localparam logic [REG_W-1:0] REG_SIZE_ZERO    = 3'd1;
	localparam logic [REG_W-1:0] REG_SIZE_ONE     = 3'd2;
	localparam logic [REG_W-1:0] REG_SIZE_TWO     = 3'd3;
	localparam logic [REG_W-1:0] REG_SIZE_THREE   = 3'd4;

	typedef enum logic {OP_ACCESS = 1'b0, OP_REPORT = 1'b1} op_t;

	// word handed from lookup front to counter back
	typedef struct packed {
		op_t              op;
		logic             found;
		logic [POS_W-1:0] pos;
	} cls_t;

	typedef enum logic {BK_IDLE, BK_REPORT} bk_state_t;
endpackage

// File: sv/lru_multi_size_miss_counter.sv
// ----------------------------------------------------------------------------
// LRU multi-size miss counter
// Stack-distance profiler for up to four LRU cache sizes.
// ----------------------------------------------------------------------------
// channel  dir  tdata                  tuser               other
// s_axis   in   [23:0] address         [0] mode            -
// m_axis   out  [31:0] miss_count      [1:0] cache_index   tlast = last
// cfg      in   -                      -                   cfg_we, cfg_index (3b), cfg_data (9b)
// Access: one word per cycle while the queue has room; the front compares all 256 stack cells at once.
// Report: one result per cycle from the back while m_axis_tready is high, one per size in use;
// the front keeps accepting into the two-word queue meanwhile.
// Reset clears valid bits and counters and sets config to defaults at once; no clearing pass.
`include "assert_macros.svh"
module lru_multi_size_miss_counter import lru_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_W-1:0]     cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [ADDR_BITS-1:0] s_axis_tdata,  // [23:0] address
	input  logic                 s_axis_tuser,  // [0] mode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [CNT_W-1:0]     m_axis_tdata,  // [31:0] miss_count
	output logic [IDX_W-1:0]     m_axis_tuser,  // [1:0] cache_index
	output logic                 m_axis_tlast
);
	logic cls_valid, cls_ready, q_valid, q_ready;
	cls_t cls_word, q_word;

	lru_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_op(op_t'(s_axis_tuser)), .in_addr(s_axis_tdata),
		.cls_valid, .cls_ready, .cls_word
	);

	lru_queue u_queue (
		.clk, .arst_n,
		.wr_valid(cls_valid), .wr_ready(cls_ready), .wr_word(cls_word),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_word(q_word)
	);

	lru_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.q_valid, .q_ready, .q_word,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_idx(m_axis_tuser), .out_cnt(m_axis_tdata), .out_last(m_axis_tlast)
	);

	`ASSERT_IMP(a_hit_in_range, cls_valid && cls_word.found,
		cls_word.pos < POS_W'(STACK_DEPTH))
	`ASSERT_IMP(a_miss_pos, cls_valid && !cls_word.found,
		cls_word.pos == POS_W'(STACK_DEPTH))
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata, m_axis_tlast}))
endmodule

// File: sv/lru_front.sv
// ----------------------------------------------------------------------------
// LRU front
// Recency stack of cells: broadcast compare, priority find, shift to top.
// ----------------------------------------------------------------------------
module lru_front import lru_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  op_t                  in_op,
	input  logic [ADDR_BITS-1:0] in_addr,
	output logic                 cls_valid,
	input  logic                 cls_ready,
	output cls_t                 cls_word
);
	logic [ADDR_BITS-1:0] stack_q [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] valid_q;
	logic [STACK_DEPTH-1:0] match;
	logic [STACK_DEPTH-1:0] shift_en;
	logic [POS_W-1:0] pos;
	logic found;
	logic take;

	assign in_ready = cls_ready;
	assign take = in_valid && in_ready;
	assign cls_valid = in_valid;

	always_comb begin
		for (int k = 0; k < STACK_DEPTH; k++) match[k] = valid_q[k] && (stack_q[k] == in_addr);
	end

	// first match wins; cells above it shift down, all of them on a miss
	always_comb begin
		pos = POS_W'(STACK_DEPTH);
		found = 1'b0;
		shift_en = '0;
		for (int k = STACK_DEPTH - 1; k >= 0; k--) begin
			if (match[k]) begin
				pos = POS_W'(k);
				found = 1'b1;
			end
		end
		for (int k = 1; k < STACK_DEPTH; k++) begin
			shift_en[k] = !found || (POS_W'(k) <= pos);
		end
	end

	assign cls_word = '{op: in_op, found: found, pos: pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (take && in_op == OP_ACCESS) begin
			valid_q[0] <= 1'b1;
			for (int k = 1; k < STACK_DEPTH; k++) begin
				if (shift_en[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_op == OP_ACCESS) begin
			stack_q[0] <= in_addr;
			for (int k = 1; k < STACK_DEPTH; k++) begin
				if (shift_en[k]) stack_q[k] <= stack_q[k-1];
			end
		end
	end
endmodule

// File: sv/lru_queue.sv
// ----------------------------------------------------------------------------
// LRU queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module lru_queue import lru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cls_t wr_word,
	output logic rd_valid,
	input  logic rd_ready,
	output cls_t rd_word
);
	cls_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_word = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_word;
	end
endmodule

// File: sv/lru_back.sv
// ----------------------------------------------------------------------------
// LRU back
// Miss counters, configuration and report sequencer with output register.
// ----------------------------------------------------------------------------
module lru_back import lru_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [REG_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              q_valid,
	output logic              q_ready,
	input  cls_t              q_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  out_idx,
	output logic [CNT_W-1:0]  out_cnt,
	output logic              out_last
);
	logic [NS_W-1:0]   nsizes_q;
	logic [SIZE_W-1:0] size_q [NUM_SIZES];
	logic [CNT_W-1:0]  cnt_q [NUM_SIZES];
	logic [CNT_W-1:0]  snap_q [NUM_SIZES];
	bk_state_t state_q, state_d;
	logic [IDX_W-1:0] rix_q;
	logic [NS_W-1:0] active;
	logic slot_free, emit, take;

	assign active = (nsizes_q > NS_W'(NUM_SIZES)) ? NS_W'(NUM_SIZES) : nsizes_q;
	assign slot_free = !out_valid || out_ready;
	assign emit = state_q == BK_REPORT && slot_free;

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_ready = 1'b1;
				if (q_valid && q_word.op == OP_REPORT && active != '0) state_d = BK_REPORT;
			end
			BK_REPORT: begin
				if (emit && NS_W'(rix_q) + 1'b1 == active) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end
	assign take = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			nsizes_q <= NS_W'(1);
			for (int k = 0; k < NUM_SIZES; k++) begin
				size_q[k] <= SIZE_W'(1);
				cnt_q[k] <= '0;
			end
			rix_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SIZES_IN_USE: nsizes_q <= cfg_data[NS_W-1:0];
					REG_SIZE_ZERO:    size_q[0] <= cfg_data;
					REG_SIZE_ONE:     size_q[1] <= cfg_data;
					REG_SIZE_TWO:     size_q[2] <= cfg_data;
					REG_SIZE_THREE:   size_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (take && q_word.op == OP_ACCESS) begin
				for (int k = 0; k < NUM_SIZES; k++) begin
					if (NS_W'(k) < active && cnt_q[k] != '1 &&
					    (!q_word.found || {1'b0, q_word.pos} >= (POS_W+1)'(size_q[k])))
						cnt_q[k] <= cnt_q[k] + 1'b1;
				end
			end
			if (take && q_word.op == OP_REPORT) begin
				for (int k = 0; k < NUM_SIZES; k++) cnt_q[k] <= '0;
				rix_q <= '0;
			end else if (emit) begin
				rix_q <= rix_q + 1'b1;
			end
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_word.op == OP_REPORT) begin
			for (int k = 0; k < NUM_SIZES; k++) snap_q[k] <= cnt_q[k];
		end
		if (emit) begin
			out_idx <= rix_q;
			out_cnt <= snap_q[rix_q];
			out_last <= NS_W'(rix_q) + 1'b1 == active;
		end
	end
endmodule
